// ----- design/sfs_pkg.sv -----
`default_nettype none

package sfs_pkg;

   // Fault codes as reported on the result channel
   typedef enum logic [2:0] {
      FAULT_NONE      = 3'd0,
      FAULT_COMM      = 3'd1,
      FAULT_TRANSPORT = 3'd2,
      FAULT_BUS       = 3'd3,
      FAULT_PANIC     = 3'd4,
      FAULT_STUCK     = 3'd5
   } fault_type;

   // Register indexes on the csr port
   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_COMM_TIMEOUT = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_KEY_HOLD = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_IDLE_DELAY   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_IDLE_SHED    = 3'd3;

   localparam int MsWidth   = 23;
   localparam int TimeWidth = 32;
   localparam int MaskWidth = 32;

   localparam logic [9:0] US_PER_MS = 10'd1000;

   // Reset limits, already in microseconds
   localparam logic [TimeWidth-1:0] COMM_LIMIT_RESET = 32'd1000000;
   localparam logic [TimeWidth-1:0] HOLD_LIMIT_RESET = 32'd10000000;
   localparam logic [TimeWidth-1:0] IDLE_LIMIT_RESET = 32'd5000000;

   // Limits handed from the register block to the core
   typedef struct packed {
      logic [TimeWidth-1:0] comm_us;
      logic [TimeWidth-1:0] hold_us;
      logic [TimeWidth-1:0] idle_us;
      logic                 shed_en;
   } sfs_limits_type;

   // Control common to every key cell
   typedef struct packed {
      logic                 scan;
      logic [TimeWidth-1:0] now_us;
      logic [TimeWidth-1:0] hold_us;
   } sfs_cell_ctrl_type;

   // Milliseconds to microseconds, saturating at the top of the time range
   function automatic logic [TimeWidth-1:0] ms_to_us(input logic [MsWidth-1:0] ms);
      logic [MsWidth+9:0] prod;
      prod = {10'b0, ms} * {{MsWidth{1'b0}}, US_PER_MS};
      return prod[MsWidth+9:TimeWidth] != '0 ? {TimeWidth{1'b1}} : prod[TimeWidth-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/sfs_csr.sv -----
`default_nettype none

module sfs_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [sfs_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [sfs_pkg::MsWidth-1:0]          csr_wdata,
   output sfs_pkg::sfs_limits_type                   limits
);
   import sfs_pkg::*;

   logic [TimeWidth-1:0] comm_us_ff;
   logic [TimeWidth-1:0] hold_us_ff;
   logic [TimeWidth-1:0] idle_us_ff;
   logic                 shed_en_ff;
   logic [TimeWidth-1:0] wdata_us;

   // Convert on the write so the core always sees microsecond limits
   assign wdata_us = ms_to_us(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         comm_us_ff <= COMM_LIMIT_RESET;
         hold_us_ff <= HOLD_LIMIT_RESET;
         idle_us_ff <= IDLE_LIMIT_RESET;
         shed_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COMM_TIMEOUT: comm_us_ff <= wdata_us;
            CSR_MAX_KEY_HOLD: hold_us_ff <= wdata_us;
            CSR_IDLE_DELAY:   idle_us_ff <= wdata_us;
            CSR_IDLE_SHED:    shed_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign limits = '{comm_us: comm_us_ff, hold_us: hold_us_ff,
                     idle_us: idle_us_ff, shed_en: shed_en_ff};

endmodule

`default_nettype wire

// ----- design/sfs_key_cell.sv -----
`default_nettype none

module sfs_key_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sfs_pkg::sfs_cell_ctrl_type ctrl,
   input  wire logic                       pressed,
   input  wire logic                       stuck_in,
   output logic                            stuck_out
);
   import sfs_pkg::*;

   logic                 prev_ff;
   logic                 stuck_ff;
   logic                 stuck_in_cell;
   logic                 rising;
   logic [TimeWidth-1:0] press_ff;
   logic [TimeWidth-1:0] held;

   // Newly pressed keys restart their hold time at this tick
   assign rising = pressed & ~prev_ff;
   assign held   = ctrl.now_us - press_ff;
   assign stuck_in_cell = pressed & ~rising & (held > ctrl.hold_us);

   // Press time of this key; only read once a rising edge has written it
   always_ff @(posedge clock) begin
      if (ctrl.scan && rising) begin
         press_ff <= ctrl.now_us;
      end
   end

   // Hold the previous mask bit and the verdict of the last scan
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         stuck_ff <= 1'b0;
      end else if (ctrl.scan) begin
         prev_ff  <= pressed;
         stuck_ff <= stuck_in_cell;
      end
   end

   // Pass the running stuck flag on to the next cell
   assign stuck_out = stuck_in | stuck_ff;

endmodule

`default_nettype wire

// ----- design/safety_fault_supervisor_core.sv -----
`default_nettype none

// Safety fault supervisor. Each tick beat carries the time in microseconds,
// link, bus health, active key count, sound demand, the physical key mask and
// the clear, panic and MIDI event flags; the block answers every tick with
// one beat holding the latched fault code, the output enable and a sound-off
// pulse that is high when a fault was entered in that tick. Panic, bus, comm
// watchdog and stuck key faults are checked in that order, a later one
// overwriting an earlier one; bus and link faults recover by themselves,
// panic and stuck key need clear. Limits are written in milliseconds on the
// csr port; the user must do so only while no tick is in flight, as the block
// does not enforce it. A tick passes through capture, a scan in which the row
// of key cells (one per key, holding its press time) compares every hold time
// at once, and a resolve step that updates the fault state and loads the
// result register; resolve waits while that register still holds an untaken
// beat. The next tick is taken as soon as resolve is done.

module safety_fault_supervisor_core #(
   parameter int NUM_KEYS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [sfs_pkg::TimeWidth-1:0]        req_now_us,
   input  wire logic                                 req_link_up,
   input  wire logic                                 req_bus_healthy,
   input  wire logic [5:0]                           req_active_keys,
   input  wire logic                                 req_sound_wanted,
   input  wire logic [sfs_pkg::MaskWidth-1:0]        req_key_mask,
   input  wire logic                                 req_midi_seen,
   input  wire logic                                 req_panic_req,
   input  wire logic                                 req_clear_req,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [2:0]                                rsp_fault_code,
   output logic                                      rsp_outputs_on,
   output logic                                      rsp_sound_off,
   input  wire logic                                 csr_wr_en,
   input  wire logic [sfs_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [sfs_pkg::MsWidth-1:0]          csr_wdata
);
   import sfs_pkg::*;

   // Keys at or above the mask width are never pressed and get no cell
   localparam int CellCount = NUM_KEYS < MaskWidth ? NUM_KEYS : MaskWidth;

   typedef enum logic [2:0] {
      S_IDLE    = 3'b001,
      S_SCAN    = 3'b010,
      S_RESOLVE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   sfs_limits_type    limits;
   sfs_cell_ctrl_type cell_ctrl;
   logic [CellCount:0] stuck_chain;

   // Captured tick
   logic [TimeWidth-1:0] now_ff;
   logic                 link_ff;
   logic                 bus_ff;
   logic [5:0]           keys_ff;
   logic                 sound_ff;
   logic [MaskWidth-1:0] mask_ff;
   logic                 midi_ff;
   logic                 panic_ff;
   logic                 clear_ff;

   // Supervisor state
   logic [TimeWidth-1:0] last_act_ff, last_act_in;
   logic                 act_flag_ff, act_flag_in;
   logic                 ever_link_ff, ever_link_in;
   fault_type            fault_ff, fault_in;
   logic [TimeWidth-1:0] fault_time_ff, fault_time_in;
   logic                 off_ff, off_in;
   logic                 idle_trk_ff, idle_trk_in;
   logic [TimeWidth-1:0] idle_since_ff, idle_since_in;

   // Compares taken in the scan cycle against the state before the tick
   logic comm_gt_ff;
   logic idle_gt_ff;
   logic ftime_eq_ff;

   // Result register
   logic       rsp_valid_ff;
   fault_type  rsp_fault_ff;
   logic       rsp_on_ff;
   logic       rsp_pulse_ff;

   logic       in_take;
   logic       slot_free;
   logic       commit;
   logic       pulse;
   logic       entered;
   fault_type  comm_code;
   logic       comm_trip;

   sfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   // Row of key cells, stuck flags chained from key 0 upwards
   assign cell_ctrl = '{scan: state_ff == S_SCAN, now_us: now_ff, hold_us: limits.hold_us};
   assign stuck_chain[0] = 1'b0;

   for (genvar k = 0; k < CellCount; k++) begin : g_cell
      sfs_key_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .pressed   (mask_ff[k]),
         .stuck_in  (stuck_chain[k]),
         .stuck_out (stuck_chain[k+1])
      );
   end

   // Handshakes
   assign req_stall = state_ff != S_IDLE;
   assign in_take   = req_valid & ~req_stall;
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign commit    = (state_ff == S_RESOLVE) & slot_free;

   // Sequence one tick through capture, scan and resolve
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (in_take) state_in = S_SCAN;
         S_SCAN:    state_in = S_RESOLVE;
         S_RESOLVE: if (slot_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the tick beat
   always_ff @(posedge clock) begin
      if (in_take) begin
         now_ff   <= req_now_us;
         link_ff  <= req_link_up;
         bus_ff   <= req_bus_healthy;
         keys_ff  <= req_active_keys;
         sound_ff <= req_sound_wanted;
         mask_ff  <= req_key_mask;
         midi_ff  <= req_midi_seen;
         panic_ff <= req_panic_req;
         clear_ff <= req_clear_req;
      end
   end

   // Time compares against the state as it stood before this tick
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN) begin
         comm_gt_ff  <= (now_ff - last_act_ff) > limits.comm_us;
         idle_gt_ff  <= (now_ff - idle_since_ff) > limits.idle_us;
         ftime_eq_ff <= now_ff == fault_time_ff;
      end
   end

   assign comm_code = ever_link_in ? FAULT_TRANSPORT : FAULT_COMM;
   // A MIDI beat in this tick leaves zero silence
   assign comm_trip = ~link_ff & act_flag_in & ~midi_ff & comm_gt_ff & (keys_ff != 6'd0);

   // Resolve the tick: events, fault checks, idle shedding, recovery
   always_comb begin
      fault_in      = fault_ff;
      fault_time_in = fault_time_ff;
      off_in        = off_ff;
      idle_trk_in   = idle_trk_ff;
      idle_since_in = idle_since_ff;
      pulse         = 1'b0;
      entered       = 1'b0;

      act_flag_in  = act_flag_ff | midi_ff;
      last_act_in  = midi_ff ? now_ff : last_act_ff;
      ever_link_in = ever_link_ff | link_ff;

      if (clear_ff) begin
         fault_in = FAULT_NONE;
         off_in   = 1'b0;
      end
      if (panic_ff && fault_in != FAULT_PANIC) begin
         fault_in = FAULT_PANIC;
         entered  = 1'b1;
      end
      if (!bus_ff && fault_in != FAULT_BUS) begin
         fault_in = FAULT_BUS;
         entered  = 1'b1;
      end
      if (comm_trip && fault_in != comm_code) begin
         fault_in = comm_code;
         entered  = 1'b1;
      end
      if (stuck_chain[CellCount] && fault_in != FAULT_STUCK) begin
         fault_in = FAULT_STUCK;
         entered  = 1'b1;
      end
      if (entered) begin
         fault_time_in = now_ff;
         off_in        = 1'b1;
         pulse         = 1'b1;
      end

      // Shed outputs after a quiet spell, restore them on demand
      if (fault_in == FAULT_NONE && limits.shed_en) begin
         if (keys_ff == 6'd0 && !sound_ff) begin
            if (!idle_trk_ff) begin
               idle_trk_in   = 1'b1;
               idle_since_in = now_ff;
            end else if (!off_in && idle_gt_ff) begin
               off_in = 1'b1;
            end
         end else begin
            idle_trk_in = 1'b0;
            off_in      = 1'b0;
         end
      end

      // Recover transient faults, never in the tick the fault was latched
      if (fault_in != FAULT_NONE && !entered && !ftime_eq_ff) begin
         case (fault_in)
            FAULT_BUS: begin
               if (bus_ff && link_ff) begin
                  fault_in = FAULT_NONE;
                  off_in   = 1'b0;
               end
            end
            FAULT_COMM, FAULT_TRANSPORT: begin
               if (link_ff) begin
                  fault_in = FAULT_NONE;
                  off_in   = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // Commit supervisor state at the end of resolve
   always_ff @(posedge clock) begin
      if (reset) begin
         last_act_ff   <= '0;
         act_flag_ff   <= 1'b0;
         ever_link_ff  <= 1'b0;
         fault_ff      <= FAULT_NONE;
         fault_time_ff <= '0;
         off_ff        <= 1'b0;
         idle_trk_ff   <= 1'b0;
         idle_since_ff <= '0;
      end else if (commit) begin
         last_act_ff   <= last_act_in;
         act_flag_ff   <= act_flag_in;
         ever_link_ff  <= ever_link_in;
         fault_ff      <= fault_in;
         fault_time_ff <= fault_time_in;
         off_ff        <= off_in;
         idle_trk_ff   <= idle_trk_in;
         idle_since_ff <= idle_since_in;
      end
   end

   // Result register: load on commit, drop when the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_fault_ff <= fault_in;
         rsp_on_ff    <= ~off_in;
         rsp_pulse_ff <= pulse;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fault_code = 3'(rsp_fault_ff);
   assign rsp_outputs_on = rsp_on_ff;
   assign rsp_sound_off  = rsp_pulse_ff;

endmodule

`default_nettype wire

// ----- sim/safety_fault_supervisor_checker.sv -----
`default_nettype none

// Watch the tick and status channels, predict every status beat and compare
module safety_fault_supervisor_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic [sfs_pkg::TimeWidth-1:0]     req_now_us,
   input  wire logic                              req_link_up,
   input  wire logic                              req_bus_healthy,
   input  wire logic [5:0]                        req_active_keys,
   input  wire logic                              req_sound_wanted,
   input  wire logic [sfs_pkg::MaskWidth-1:0]     req_key_mask,
   input  wire logic                              req_midi_seen,
   input  wire logic                              req_panic_req,
   input  wire logic                              req_clear_req,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic [2:0]                        rsp_fault_code,
   input  wire logic                              rsp_outputs_on,
   input  wire logic                              rsp_sound_off,
   input  wire logic                              csr_wr_en,
   input  wire logic [sfs_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [sfs_pkg::MsWidth-1:0]       csr_wdata,
   output int                                     outstanding,
   output int                                     error_count
);
   import sfs_pkg::*;

   typedef struct packed {
      logic [2:0] fault_code;
      logic       outputs_on;
      logic       sound_off;
   } status_type;

   status_type expected_status_q[$];

   // Limits in milliseconds as last written
   logic [MsWidth-1:0] comm_ms;
   logic [MsWidth-1:0] hold_ms;
   logic [MsWidth-1:0] idle_ms;
   logic               shed_en;

   // Supervisor state
   logic [31:0] last_act;
   logic        act_seen;
   logic        linked_once;
   fault_type   fault;
   logic [31:0] fault_at;
   logic        outs_off;
   logic        idle_armed;
   logic [31:0] idle_from;
   logic [31:0] press_at [32];
   logic [31:0] mask_prev;
   logic        entered;

   // Milliseconds to microseconds, saturating at the top of 32 bits
   function automatic logic [31:0] limit_us(logic [MsWidth-1:0] ms);
      logic [63:0] prod;
      prod = {41'd0, ms} * 64'd1000;
      return (prod[63:32] != 32'd0) ? 32'hFFFF_FFFF : prod[31:0];
   endfunction

   // Latch a fault only when it differs from the one held
   function automatic void latch_fault(fault_type code, logic [31:0] now);
      if (fault != code) begin
         fault    = code;
         fault_at = now;
         outs_off = 1'b1;
         entered  = 1'b1;
      end
   endfunction

   function automatic void clear_supervisor();
      comm_ms     = 23'd1000;
      hold_ms     = 23'd10000;
      idle_ms     = 23'd5000;
      shed_en     = 1'b0;
      last_act    = '0;
      act_seen    = 1'b0;
      linked_once = 1'b0;
      fault       = FAULT_NONE;
      fault_at    = '0;
      outs_off    = 1'b0;
      idle_armed  = 1'b0;
      idle_from   = '0;
      mask_prev   = '0;
      entered     = 1'b0;
      for (int k = 0; k < 32; k++) press_at[k] = '0;
   endfunction

   // One supervisor tick: events, press times, checks, then recovery
   function automatic status_type supervise_tick(
      logic [31:0] now, logic link, logic bus_ok, logic [5:0] keys, logic sound,
      logic [31:0] mask, logic midi, logic panic, logic clear);
      logic [31:0] rising;
      logic        stuck;
      logic        recover;
      status_type  s;
      entered = 1'b0;
      if (clear) begin
         fault    = FAULT_NONE;
         outs_off = 1'b0;
      end
      if (panic) latch_fault(FAULT_PANIC, now);
      if (midi) begin
         last_act = now;
         act_seen = 1'b1;
      end

      rising = mask & ~mask_prev;
      for (int k = 0; k < 32; k++)
         if (rising[k]) press_at[k] = now;
      mask_prev = mask;

      if (link) linked_once = 1'b1;

      if (!bus_ok) latch_fault(FAULT_BUS, now);

      // comm watchdog: link down, activity seen, silence too long, keys sounding
      if (!link && act_seen && ((now - last_act) > limit_us(comm_ms)) && keys != 6'd0) begin
         if (linked_once) latch_fault(FAULT_TRANSPORT, now);
         else latch_fault(FAULT_COMM, now);
      end

      stuck = 1'b0;
      for (int k = 0; k < 32; k++)
         if (!stuck && mask[k] && ((now - press_at[k]) > limit_us(hold_ms))) stuck = 1'b1;
      if (stuck) latch_fault(FAULT_STUCK, now);

      // shed outputs after a quiet spell, restore them on demand
      if (fault == FAULT_NONE && shed_en) begin
         if (keys == 6'd0 && !sound) begin
            if (!idle_armed) begin
               idle_armed = 1'b1;
               idle_from  = now;
            end else if (!outs_off && ((now - idle_from) > limit_us(idle_ms))) begin
               outs_off = 1'b1;
            end
         end else begin
            idle_armed = 1'b0;
            outs_off   = 1'b0;
         end
      end

      // transient faults recover, never in the tick that latched them
      if (fault != FAULT_NONE && now != fault_at) begin
         case (fault)
            FAULT_BUS:                  recover = bus_ok && link;
            FAULT_TRANSPORT, FAULT_COMM: recover = link;
            default:                    recover = 1'b0;
         endcase
         if (recover) begin
            fault    = FAULT_NONE;
            outs_off = 1'b0;
         end
      end

      s.fault_code = fault;
      s.outputs_on = !outs_off;
      s.sound_off  = entered;
      return s;
   endfunction

   task automatic report_mismatch(string what, status_type want, status_type seen);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s: expected fault %0d outputs_on %0b sound_off %0b, %s",
                  $time, what, want.fault_code, want.outputs_on, want.sound_off,
                  $sformatf("got fault %0d outputs_on %0b sound_off %0b",
                            seen.fault_code, seen.outputs_on, seen.sound_off));
   endtask

   initial begin
      error_count = 0;
      outstanding = 0;
      clear_supervisor();
   end

   // Take the status beat first, so a tick accepted on the same edge queues behind it
   always @(posedge clock) begin
      status_type want;
      status_type seen;
      int         pushes;
      int         pops;
      pushes = 0;
      pops   = 0;
      if (reset) begin
         clear_supervisor();
         expected_status_q.delete();
         outstanding <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COMM_TIMEOUT: comm_ms = csr_wdata;
               CSR_MAX_KEY_HOLD: hold_ms = csr_wdata;
               CSR_IDLE_DELAY:   idle_ms = csr_wdata;
               CSR_IDLE_SHED:    shed_en = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_fault_code, rsp_outputs_on, rsp_sound_off};
            if (expected_status_q.size() == 0) begin
               report_mismatch("status beat with no tick pending", '0, seen);
            end else begin
               want = expected_status_q.pop_front();
               pops = 1;
               if (want !== seen) report_mismatch("status beat mismatch", want, seen);
            end
         end
         if (req_valid && !req_stall) begin
            expected_status_q.push_back(supervise_tick(req_now_us, req_link_up, req_bus_healthy,
                                                       req_active_keys, req_sound_wanted,
                                                       req_key_mask, req_midi_seen,
                                                       req_panic_req, req_clear_req));
            pushes = 1;
         end
         outstanding <= outstanding + pushes - pops;
      end
   end

endmodule

`default_nettype wire

// ----- sim/safety_fault_supervisor_core_tb.sv -----
`default_nettype none

module safety_fault_supervisor_core_tb;
   import sfs_pkg::*;

   localparam int QuietLimit  = 5000;
   localparam int PhaseTicks  = 155;
   localparam int PhaseCount  = 10;
   localparam int TailCycles  = 20;

   typedef struct packed {
      logic [31:0] now_us;
      logic        link_up;
      logic        bus_healthy;
      logic [5:0]  active_keys;
      logic        sound_wanted;
      logic [31:0] key_mask;
      logic        midi_seen;
      logic        panic_req;
      logic        clear_req;
   } tick_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [TimeWidth-1:0]     req_now_us;
   logic                     req_link_up;
   logic                     req_bus_healthy;
   logic [5:0]               req_active_keys;
   logic                     req_sound_wanted;
   logic [MaskWidth-1:0]     req_key_mask;
   logic                     req_midi_seen;
   logic                     req_panic_req;
   logic                     req_clear_req;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [2:0]               rsp_fault_code;
   logic                     rsp_outputs_on;
   logic                     rsp_sound_off;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [MsWidth-1:0]       csr_wdata;

   int          outstanding;
   int          error_count;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int unsigned quiet_cycles = 0;

   // Running scenario for the random ticks
   logic [31:0] cur_now  = '0;
   logic [31:0] cur_mask = '0;
   logic        cur_link = 1'b0;
   logic        cur_sound = 1'b0;

   safety_fault_supervisor_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_now_us       (req_now_us),
      .req_link_up      (req_link_up),
      .req_bus_healthy  (req_bus_healthy),
      .req_active_keys  (req_active_keys),
      .req_sound_wanted (req_sound_wanted),
      .req_key_mask     (req_key_mask),
      .req_midi_seen    (req_midi_seen),
      .req_panic_req    (req_panic_req),
      .req_clear_req    (req_clear_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fault_code   (rsp_fault_code),
      .rsp_outputs_on   (rsp_outputs_on),
      .rsp_sound_off    (rsp_sound_off),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   safety_fault_supervisor_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_now_us       (req_now_us),
      .req_link_up      (req_link_up),
      .req_bus_healthy  (req_bus_healthy),
      .req_active_keys  (req_active_keys),
      .req_sound_wanted (req_sound_wanted),
      .req_key_mask     (req_key_mask),
      .req_midi_seen    (req_midi_seen),
      .req_panic_req    (req_panic_req),
      .req_clear_req    (req_clear_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fault_code   (rsp_fault_code),
      .rsp_outputs_on   (rsp_outputs_on),
      .rsp_sound_off    (rsp_sound_off),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .outstanding      (outstanding),
      .error_count      (error_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the status channel at the rate of the current phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Drop the run when neither channel nor the csr port moves for too long
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic tick_type mk_tick(logic [31:0] now_us, logic link_up, logic bus_healthy,
                                        logic [5:0] active_keys, logic sound_wanted,
                                        logic [31:0] key_mask, logic midi_seen,
                                        logic panic_req, logic clear_req);
      return '{now_us, link_up, bus_healthy, active_keys, sound_wanted, key_mask,
               midi_seen, panic_req, clear_req};
   endfunction

   // Advance time and key state the way a running instrument would, with some noise
   function automatic tick_type next_random_tick();
      tick_type   t;
      int         r;
      logic [4:0] k;
      r = $urandom_range(99);
      if (r < 5) cur_now = cur_now;
      else if (r < 60) cur_now = cur_now + $urandom_range(3000);
      else if (r < 85) cur_now = cur_now + $urandom_range(30000);
      else if (r < 95) cur_now = cur_now + $urandom_range(3000000);
      else cur_now = $urandom;

      r = $urandom_range(99);
      if (r < 60) cur_mask = cur_mask;
      else if (r < 85) begin
         k = 5'($urandom_range(31));
         cur_mask[k] = ~cur_mask[k];
      end else if (r < 93) cur_mask = '0;
      else if (r < 97) cur_mask = $urandom;
      else cur_mask = '1;

      if ($urandom_range(99) < 10) cur_link = !cur_link;
      if ($urandom_range(99) < 20) cur_sound = !cur_sound;

      t.now_us       = cur_now;
      t.link_up      = cur_link;
      t.bus_healthy  = ($urandom_range(99) >= 8);
      r = $urandom_range(99);
      if (r < 40) t.active_keys = 6'd0;
      else if (r < 90) t.active_keys = 6'($urandom_range(1, 32));
      else t.active_keys = 6'($urandom_range(33, 63));
      t.sound_wanted = cur_sound;
      t.key_mask     = cur_mask;
      t.midi_seen    = ($urandom_range(99) < 30);
      t.panic_req    = ($urandom_range(99) < 3);
      t.clear_req    = ($urandom_range(99) < 8);
      return t;
   endfunction

   // Present one tick beat, after an optional gap, and hold it until taken
   task automatic send_tick(input tick_type t);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_now_us       <= t.now_us;
      req_link_up      <= t.link_up;
      req_bus_healthy  <= t.bus_healthy;
      req_active_keys  <= t.active_keys;
      req_sound_wanted <= t.sound_wanted;
      req_key_mask     <= t.key_mask;
      req_midi_seen    <= t.midi_seen;
      req_panic_req    <= t.panic_req;
      req_clear_req    <= t.clear_req;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait for every status beat to come back
   task automatic drain_ticks();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Write all four limits, plus one write to an unused index
   task automatic program_limits(logic [MsWidth-1:0] comm, logic [MsWidth-1:0] hold,
                                 logic [MsWidth-1:0] idle, logic shed);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_COMM_TIMEOUT;
      csr_wdata <= comm;
      @(posedge clock);
      csr_index <= CSR_MAX_KEY_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      csr_index <= CSR_IDLE_DELAY;
      csr_wdata <= idle;
      @(posedge clock);
      csr_index <= CSR_IDLE_SHED;
      csr_wdata <= {22'($urandom), shed};
      @(posedge clock);
      csr_index <= 3'($urandom_range(CSR_IDLE_SHED + 1, (1 << CsrIndexWidth) - 1));
      csr_wdata <= 23'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int ph;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_now_us       = '0;
      req_link_up      = 1'b0;
      req_bus_healthy  = 1'b0;
      req_active_keys  = '0;
      req_sound_wanted = 1'b0;
      req_key_mask     = '0;
      req_midi_seen    = 1'b0;
      req_panic_req    = 1'b0;
      req_clear_req    = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short limits so every check fires within a few ticks
      program_limits(23'd2, 23'd3, 23'd1, 1'b1);
      send_tick(mk_tick(32'd0,     1'b0, 1'b1, 6'd0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd1500,  1'b0, 1'b1, 6'd0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd1600,  1'b0, 1'b1, 6'd1, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd2000,  1'b0, 1'b1, 6'd1, 1'b1, 32'd0, 1'b1, 1'b0, 1'b0));
      // silence with the link never up, then a same-time link-up that must not recover
      send_tick(mk_tick(32'd5000,  1'b0, 1'b1, 6'd1, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd5000,  1'b1, 1'b1, 6'd1, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd6000,  1'b1, 1'b1, 6'd1, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd9000,  1'b0, 1'b1, 6'd1, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      // bus fault overwritten by transport loss in the same tick
      send_tick(mk_tick(32'd9500,  1'b0, 1'b0, 6'd1, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd9600,  1'b0, 1'b0, 6'd0, 1'b1, 32'd0, 1'b1, 1'b0, 1'b0));
      send_tick(mk_tick(32'd9700,  1'b1, 1'b0, 6'd0, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd9800,  1'b1, 1'b1, 6'd0, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      // panic holds until cleared; clear with panic re-enters it
      send_tick(mk_tick(32'd10000, 1'b1, 1'b1, 6'd1, 1'b1, 32'd0, 1'b0, 1'b1, 1'b0));
      send_tick(mk_tick(32'd10100, 1'b1, 1'b1, 6'd1, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd10200, 1'b1, 1'b1, 6'd1, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
      send_tick(mk_tick(32'd10300, 1'b1, 1'b1, 6'd1, 1'b1, 32'd0, 1'b0, 1'b0, 1'b1));
      // every key held past the limit, cleared while still held
      send_tick(mk_tick(32'd11000, 1'b1, 1'b1, 6'd1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd14500, 1'b1, 1'b1, 6'd1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'd14600, 1'b1, 1'b1, 6'd1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1));
      send_tick(mk_tick(32'd14700, 1'b1, 1'b1, 6'd1, 1'b1, 32'd0, 1'b0, 1'b0, 1'b1));
      // time wraps between activity and the next tick
      send_tick(mk_tick(32'hFFFF_FF00, 1'b0, 1'b1, 6'd5, 1'b0, 32'h8000_0001,
                        1'b1, 1'b0, 1'b0));
      send_tick(mk_tick(32'h0000_0100, 1'b0, 1'b1, 6'd5, 1'b0, 32'h8000_0001,
                        1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 6'd63, 1'b1, 32'hFFFF_FFFF,
                        1'b1, 1'b1, 1'b1));
      send_tick(mk_tick(32'd0,     1'b0, 1'b0, 6'd0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0));
      drain_ticks();

      // random phases, each with its own limits and idling pattern
      for (ph = 0; ph < PhaseCount; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         case (ph)
            0: program_limits(23'd3, 23'd8, 23'd2, 1'b1);
            1: program_limits(23'd0, 23'd0, 23'd0, 1'b1);
            2: program_limits(23'h7F_FFFF, 23'h7F_FFFF, 23'h7F_FFFF, 1'b0);
            3: program_limits(23'd4294967, 23'd4294968, 23'd4294967, 1'b1);
            4: program_limits(23'd1000, 23'd10000, 23'd5000, 1'b0);
            5: program_limits(23'd1, 23'd5, 23'd1, 1'b1);
            default: program_limits(23'($urandom_range(12)), 23'($urandom_range(40)),
                                    23'($urandom_range(12)), 1'($urandom_range(1)));
         endcase
         repeat (PhaseTicks) send_tick(next_random_tick());
         drain_ticks();
      end

      repeat (TailCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
design/sfs_pkg.sv
design/sfs_csr.sv
design/sfs_key_cell.sv
design/safety_fault_supervisor_core.sv
sim/safety_fault_supervisor_checker.sv
sim/safety_fault_supervisor_core_tb.sv
